### sv/spss_pkg.sv
// Shared types and constants of the strict priority single server.
package spss_pkg;

  localparam int unsigned ItemQDepth = 2;
  localparam int unsigned ItemQPtrW  = $clog2(ItemQDepth);
  localparam int unsigned ItemQCntW  = $clog2(ItemQDepth + 1);
  localparam int unsigned IdW        = 16;
  localparam int unsigned LenW       = 16;
  localparam int unsigned TickW      = 32;
  localparam int unsigned WordW      = IdW + LenW;
  localparam logic [1:0]  PLATINUM   = 2'd3;

  typedef enum logic {
    OP_ARRIVAL = 1'b0,
    OP_TICK    = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    EV_QUEUED   = 3'd0,
    EV_DROPPED  = 3'd1,
    EV_IDLE     = 3'd2,
    EV_ANSWERED = 3'd3,
    EV_BUSY     = 3'd4
  } event_kind_e;

  typedef enum logic {
    BK_IDLE,
    BK_POP
  } back_state_e;

  typedef struct packed {
    opcode_e          opcode;
    logic [IdW-1:0]   caller_id;
    logic [1:0]       caller_class;
    logic [LenW-1:0]  service_length;
    logic             more_pending;
  } in_item_t;

  typedef struct packed {
    event_kind_e      event_kind;
    logic [IdW-1:0]   answered_id;
    logic [1:0]       answered_class;
    logic [TickW-1:0] tick_number;
    logic             all_done;
  } out_item_t;

  // Decoded request handed from the front to the back.
  typedef struct packed {
    logic             is_tick;
    logic             cls_ok;
    logic [IdW-1:0]   id;
    logic [1:0]       cls;
    logic [LenW-1:0]  len;
    logic             more;
  } work_t;

endpackage

### sv/spss_ram.sv
// Generic single write port, single read port RAM with registered read.
module spss_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/spss_front.sv
// Front end: decodes incoming requests and buffers them in a short queue.
module spss_front import spss_pkg::*; #(
  parameter int unsigned NUM_CLASSES = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  in_item_t in_item_i,
  output logic     in_ready_o,
  output logic     work_valid_o,
  output work_t    work_o,
  input  logic     work_ready_i
);

  work_t                mem_q [ItemQDepth];
  work_t                dec;
  logic [ItemQPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [ItemQCntW-1:0] cnt_q, cnt_d;
  logic                 push, pop;

  always_comb begin
    dec.is_tick = (in_item_i.opcode == OP_TICK);
    dec.cls_ok  = (32'(in_item_i.caller_class) < NUM_CLASSES);
    dec.id      = in_item_i.caller_id;
    dec.cls     = in_item_i.caller_class;
    dec.len     = in_item_i.service_length;
    dec.more    = in_item_i.more_pending;
  end

  assign in_ready_o   = (cnt_q != ItemQCntW'(ItemQDepth));
  assign work_valid_o = (cnt_q != '0);
  assign work_o       = mem_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = work_valid_o && work_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + ItemQPtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + ItemQPtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + ItemQCntW'(push) - ItemQCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= dec;
    end
  end

endmodule

### sv/spss_back.sv
// Back end: class queues, priority pop, busy counter and result register.
module spss_back import spss_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned NUM_CLASSES = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      work_valid_i,
  input  work_t     work_i,
  output logic      work_ready_o,
  output logic      out_valid_o,
  output out_item_t out_item_o,
  input  logic      out_ready_i
);

  localparam int unsigned ClsW     = $clog2(NUM_CLASSES);
  localparam int unsigned PtrW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW     = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned AddrW    = ClsW + PtrW;
  localparam int unsigned RamDepth = 2 ** AddrW;

  logic [PtrW-1:0]  head_q [NUM_CLASSES];
  logic [PtrW-1:0]  head_d [NUM_CLASSES];
  logic [PtrW-1:0]  tail_q [NUM_CLASSES];
  logic [PtrW-1:0]  tail_d [NUM_CLASSES];
  logic [CntW-1:0]  cnt_q  [NUM_CLASSES];
  logic [CntW-1:0]  cnt_d  [NUM_CLASSES];
  logic [LenW-1:0]  busy_q, busy_d, bdec;
  logic [TickW-1:0] tick_q, tick_d;
  back_state_e      state_q, state_d;
  logic [ClsW-1:0]  sel_q, sel_d, sel, cls_idx;
  logic             done_pre_q, done_pre_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;

  logic [NUM_CLASSES-1:0] nonempty, remain;
  logic                   any, full, out_free;
  logic                   push_en, pop_en, ram_re;
  logic [PtrW-1:0]        tail_cur, head_cur;
  logic [WordW-1:0]       rdata;

  assign cls_idx  = ClsW'(work_i.cls);
  assign out_free = !out_valid_q || out_ready_i;
  assign tail_cur = tail_q[cls_idx];
  assign head_cur = head_q[sel];
  assign full     = (cnt_q[cls_idx] == CntW'(QUEUE_DEPTH));
  assign bdec     = (busy_q != '0) ? busy_q - LenW'(1) : busy_q;
  assign any      = |nonempty;

  // Highest non-empty class wins; what stays non-empty after that pop.
  always_comb begin
    sel = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      nonempty[c] = (cnt_q[c] != '0);
      if (nonempty[c]) begin
        sel = ClsW'(c);
      end
    end
    for (int c = 0; c < NUM_CLASSES; c++) begin
      remain[c] = nonempty[c] && !((sel == ClsW'(c)) && (cnt_q[c] == CntW'(1)));
    end
  end

  always_comb begin
    state_d      = state_q;
    work_ready_o = 1'b0;
    push_en      = 1'b0;
    pop_en       = 1'b0;
    ram_re       = 1'b0;
    busy_d       = busy_q;
    tick_d       = tick_q;
    sel_d        = sel_q;
    done_pre_d   = done_pre_q;
    out_valid_d  = out_ready_i ? 1'b0 : out_valid_q;
    out_d        = out_q;
    unique case (state_q)
      BK_IDLE: begin
        if (work_valid_i && out_free) begin
          work_ready_o         = 1'b1;
          out_d.tick_number    = tick_q;
          out_d.answered_class = work_i.cls;
          out_d.all_done       = 1'b0;
          if (!work_i.is_tick) begin
            out_valid_d = 1'b1;
            if (!work_i.cls_ok || full) begin
              out_d.event_kind  = EV_DROPPED;
              out_d.answered_id = '0;
            end else begin
              push_en           = 1'b1;
              out_d.event_kind  = EV_QUEUED;
              out_d.answered_id = work_i.id;
            end
          end else if ((bdec == '0) && any) begin
            // Serve: head word comes back from the RAM next cycle.
            pop_en     = 1'b1;
            ram_re     = 1'b1;
            sel_d      = sel;
            done_pre_d = !work_i.more && (remain == '0);
            state_d    = BK_POP;
          end else begin
            out_valid_d          = 1'b1;
            busy_d               = bdec;
            tick_d               = tick_q + TickW'(1);
            out_d.event_kind     = (bdec == '0) ? EV_IDLE : EV_BUSY;
            out_d.answered_id    = '0;
            out_d.answered_class = '0;
            out_d.all_done       = !work_i.more && !any && (bdec == '0);
          end
        end
      end
      BK_POP: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          busy_d               = rdata[LenW-1:0];
          tick_d               = tick_q + TickW'(1);
          out_d.event_kind     = EV_ANSWERED;
          out_d.answered_id    = rdata[WordW-1:LenW];
          out_d.answered_class = 2'(sel_q);
          out_d.tick_number    = tick_q;
          out_d.all_done       = done_pre_q && (rdata[LenW-1:0] == '0);
          state_d              = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      head_d[c] = head_q[c];
      tail_d[c] = tail_q[c];
      cnt_d[c]  = cnt_q[c];
    end
    if (push_en) begin
      tail_d[cls_idx] = (tail_cur == PtrW'(QUEUE_DEPTH - 1)) ? '0 : tail_cur + PtrW'(1);
      cnt_d[cls_idx]  = cnt_q[cls_idx] + CntW'(1);
    end
    if (pop_en) begin
      head_d[sel] = (head_cur == PtrW'(QUEUE_DEPTH - 1)) ? '0 : head_cur + PtrW'(1);
      cnt_d[sel]  = cnt_q[sel] - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head_q[c] <= '0;
        tail_q[c] <= '0;
        cnt_q[c]  <= '0;
      end
      busy_q      <= '0;
      tick_q      <= '0;
      state_q     <= BK_IDLE;
      sel_q       <= '0;
      done_pre_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head_q[c] <= head_d[c];
        tail_q[c] <= tail_d[c];
        cnt_q[c]  <= cnt_d[c];
      end
      busy_q      <= busy_d;
      tick_q      <= tick_d;
      state_q     <= state_d;
      sel_q       <= sel_d;
      done_pre_q  <= done_pre_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  spss_ram #(
    .Width (WordW),
    .Depth (RamDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (push_en),
    .waddr_i ({cls_idx, tail_cur}),
    .wdata_i ({work_i.id, work_i.len}),
    .re_i    (ram_re),
    .raddr_i ({sel, head_cur}),
    .rdata_o (rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

### sv/strict_priority_single_server.sv
// Top level of the strict priority single server scheduler.
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_item_i) carries arrivals
//   (opcode 0) and server ticks (opcode 1). Arrivals are pushed into the
//   FIFO of their class; a full FIFO drops the request. A tick counts down
//   the busy timer and, once idle, serves the head of the highest
//   non-empty class. Every request yields exactly one result on the
//   output channel (out_valid_o / out_ready_i / out_item_o), in order.
//   Results pass the request queue, back end and result register; a tick
//   that serves also waits on the class store read. Throughput: one
//   request per cycle while the receiver is ready, except a serving tick,
//   which also holds the back end in its pop state for the store's
//   registered read port. A two-entry request queue decouples input from
//   the back end. Reset clears all class queues (by their counters), the
//   busy timer and the tick counter; no clearing pass is needed. When the
//   receiver stalls, the result register holds and the back end waits; the
//   input keeps taking requests until the request queue fills.
module strict_priority_single_server import spss_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned NUM_CLASSES = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic  work_valid, work_ready;
  work_t work;

  spss_front #(
    .NUM_CLASSES (NUM_CLASSES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_item_i    (in_item_i),
    .in_ready_o   (in_ready_o),
    .work_valid_o (work_valid),
    .work_o       (work),
    .work_ready_i (work_ready)
  );

  spss_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .NUM_CLASSES (NUM_CLASSES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .work_valid_i (work_valid),
    .work_i       (work),
    .work_ready_o (work_ready),
    .out_valid_o  (out_valid_o),
    .out_item_o   (out_item_o),
    .out_ready_i  (out_ready_i)
  );

`ifndef SYNTH
  // Done can only follow a tick that left the server idle.
  a_done_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.all_done |->
      (out_item_o.event_kind == EV_IDLE) || (out_item_o.event_kind == EV_ANSWERED))
    else $error("all_done on a result that is not an idle or answering tick");

  // Results without a requester carry id zero.
  a_no_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_item_o.event_kind == EV_DROPPED) ||
      (out_item_o.event_kind == EV_IDLE) || (out_item_o.event_kind == EV_BUSY)) |->
      (out_item_o.answered_id == '0))
    else $error("nonzero id on a result without a requester");

  // The back end takes no request while a result waits for the receiver.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !work_ready)
    else $error("request taken while the result register is stalled");
`endif

endmodule
